// ===== design/gn3_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3_pkg: shared types and constants for the 3D gradient noise block
// Fixed-point formats, table geometry, action codes and the payload types
// that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int GRAD_W          = 16;
  localparam int GRAD_FRAC_BITS  = 14;
  localparam int OUT_W           = 16;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int ENTRY_W         = 8;

  localparam int TABLE_SIZE      = 256;
  localparam int IDX_W           = $clog2(TABLE_SIZE);
  localparam int LATTICE_OFFSET  = 10000;
  localparam int LAT_OFS         = LATTICE_OFFSET % TABLE_SIZE;

  // Fraction (unsigned), signed offset to a corner, smoothstep weight.
  localparam int F_W     = COORD_FRAC_BITS;
  localparam int R_W     = F_W + 1;
  localparam int S_W     = F_W + 1;
  // Gradient times offset, the sum of three of them, and the dot product.
  localparam int PROD_W  = R_W + GRAD_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DOT_W   = SUM_W - COORD_FRAC_BITS;
  // Weight times difference inside one interpolation lane.
  localparam int MUL_W   = (S_W + 1) + (DOT_W + 1);
  localparam int SCALE_SHIFT = 1 + GRAD_FRAC_BITS - OUT_FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_EVAL = 2'd0,
    ACT_PERM = 2'd1,
    ACT_GRAD = 2'd2
  } action_t;

  // Gradient: [0] x, [1] y, [2] z.
  typedef logic [2:0][GRAD_W-1:0] grad_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [2:0][COORD_W-1:0]  coord;
    logic [ENTRY_W-1:0]       entry_index;
    logic [ENTRY_W-1:0]       perm_value;
    grad_t                    grad;
  } req_t;

  // Lookup section result: offsets, weights and the eight corner gradients.
  typedef struct packed {
    logic                 eval;
    logic [2:0][F_W-1:0]  frac;
    logic [2:0][S_W-1:0]  weight;
    grad_t [7:0]          grad;
  } lookup_t;

  // Dot product section result.
  typedef struct packed {
    logic                  eval;
    logic [2:0][S_W-1:0]   weight;
    logic [7:0][DOT_W-1:0] dot;
  } corner_t;

endpackage

// ===== design/gn3_if.sv =====
// ----------------------------------------------------------------------------
// gn3_if: request and response channels of the 3D gradient noise block
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface gn3_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [7:0]         entry_index;
  logic [7:0]         perm_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, entry_index,
                  perm_value, grad_x, grad_y, grad_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, entry_index,
                  perm_value, grad_x, grad_y, grad_z, output ready);
endinterface

interface gn3_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== design/gn3_ram.sv =====
// ----------------------------------------------------------------------------
// gn3_ram: generic single-write, single-read RAM
// The read data is registered and holds while the read enable is low.
// ----------------------------------------------------------------------------
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/gn3_lookup.sv =====
// ----------------------------------------------------------------------------
// gn3_lookup: lattice setup and table lookup section
// Four stages: axis setup, first permutation read, second permutation read,
// gradient read. Table writes travel with the items and update each table
// copy at the stage that reads it, so reads and writes keep item order.
// ----------------------------------------------------------------------------
module gn3_lookup (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  gn3_pkg::req_t   in_req,
  output logic            out_valid,
  output gn3_pkg::lookup_t out_data
);

  localparam int IW = gn3_pkg::IDX_W;
  localparam int FW = gn3_pkg::F_W;
  localparam int CF = gn3_pkg::COORD_FRAC_BITS;

  // Stage A
  logic                      a_valid;
  logic [1:0]                a_op;
  logic [2:0][IW-1:0]        a_idx;
  logic [2:0][FW-1:0]        a_frac;
  logic [IW-1:0]             a_wi;
  logic [gn3_pkg::ENTRY_W-1:0] a_pv;
  gn3_pkg::grad_t            a_grad;
  // Stage B
  logic                      b_valid;
  logic [1:0]                b_op;
  logic [2:0][IW-1:0]        b_idx;
  logic [2:0][FW-1:0]        b_frac;
  logic [2:0][FW-1:0]        b_sq;
  logic [IW-1:0]             b_wi;
  logic [gn3_pkg::ENTRY_W-1:0] b_pv;
  gn3_pkg::grad_t            b_grad;
  // Stage C
  logic                      c_valid;
  logic [1:0]                c_op;
  logic [IW-1:0]             c_bz;
  logic [2:0][FW-1:0]        c_frac;
  logic [2:0][gn3_pkg::S_W-1:0] c_weight;
  logic [IW-1:0]             c_wi;
  gn3_pkg::grad_t            c_grad;
  // Stage D
  logic                      d_valid;
  logic                      d_eval;
  logic [2:0][FW-1:0]        d_frac;
  logic [2:0][gn3_pkg::S_W-1:0] d_weight;

  logic [1:0][IW-1:0]        perm_a;
  logic [3:0][IW-1:0]        perm_b;
  gn3_pkg::grad_t [7:0]      grad_rd;

  logic [2:0][IW-1:0]        idx_next;
  logic [2:0][FW-1:0]        sq_next;
  logic [2:0][gn3_pkg::S_W-1:0] weight_next;
  logic [2*FW-1:0]           sq_prod [3];
  logic [FW+1:0]             kfac [3];
  logic [2*FW+1:0]           w_prod [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      idx_next[a] = in_req.coord[a][CF+IW-1:CF] + IW'(gn3_pkg::LAT_OFS);
      sq_prod[a]  = a_frac[a] * a_frac[a];
      sq_next[a]  = sq_prod[a][2*FW-1:FW];
      kfac[a]     = (FW+2)'(3 << FW) - {1'b0, b_frac[a], 1'b0};
      w_prod[a]   = b_sq[a] * kfac[a];
      weight_next[a] = w_prod[a][2*FW:FW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= in_req.action;
      a_idx  <= idx_next;
      for (int a = 0; a < 3; a++) begin
        a_frac[a] <= in_req.coord[a][FW-1:0];
      end
      a_wi   <= in_req.entry_index[IW-1:0];
      a_pv   <= in_req.perm_value;
      a_grad <= in_req.grad;

      b_op   <= a_op;
      b_idx  <= a_idx;
      b_frac <= a_frac;
      b_sq   <= sq_next;
      b_wi   <= a_wi;
      b_pv   <= a_pv;
      b_grad <= a_grad;

      c_op     <= b_op;
      c_bz     <= b_idx[2];
      c_frac   <= b_frac;
      c_weight <= weight_next;
      c_wi     <= b_wi;
      c_grad   <= b_grad;

      d_eval   <= (c_op == gn3_pkg::ACT_EVAL);
      d_frac   <= c_frac;
      d_weight <= c_weight;
    end
  end

  // First permutation read: perm[x0], perm[x1].
  for (genvar x = 0; x < 2; x++) begin : g_perm_a
    gn3_ram #(.WIDTH(IW), .DEPTH(gn3_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (en && a_valid && (a_op == gn3_pkg::ACT_PERM)),
      .waddr (a_wi),
      .wdata (a_pv[IW-1:0]),
      .re    (en),
      .raddr (a_idx[0] + IW'(x)),
      .rdata (perm_a[x])
    );
  end

  // Second permutation read, one copy per (x, y) corner pair.
  for (genvar k = 0; k < 4; k++) begin : g_perm_b
    gn3_ram #(.WIDTH(IW), .DEPTH(gn3_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (en && b_valid && (b_op == gn3_pkg::ACT_PERM)),
      .waddr (b_wi),
      .wdata (b_pv[IW-1:0]),
      .re    (en),
      .raddr (perm_a[k%2] + b_idx[1] + IW'(k/2)),
      .rdata (perm_b[k])
    );
  end

  // Gradient read, one copy per corner {z, y, x}.
  for (genvar k = 0; k < 8; k++) begin : g_grad
    gn3_ram #(.WIDTH($bits(gn3_pkg::grad_t)), .DEPTH(gn3_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (en && c_valid && (c_op == gn3_pkg::ACT_GRAD)),
      .waddr (c_wi),
      .wdata (c_grad),
      .re    (en),
      .raddr (perm_b[k%4] + c_bz + IW'(k/4)),
      .rdata (grad_rd[k])
    );
  end

  assign out_valid       = d_valid;
  assign out_data.eval   = d_eval;
  assign out_data.frac   = d_frac;
  assign out_data.weight = d_weight;
  assign out_data.grad   = grad_rd;

endmodule

// ===== design/gn3_dot.sv =====
// ----------------------------------------------------------------------------
// gn3_dot: corner dot products
// Stage E forms the 24 gradient-times-offset products, stage F sums each
// corner's three products and drops the coordinate fraction with floor.
// ----------------------------------------------------------------------------
module gn3_dot (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  gn3_pkg::lookup_t  in_data,
  output logic              out_valid,
  output gn3_pkg::corner_t  out_data
);

  localparam int PW = gn3_pkg::PROD_W;
  localparam int SW = gn3_pkg::SUM_W;
  localparam int CF = gn3_pkg::COORD_FRAC_BITS;
  localparam int RW = gn3_pkg::R_W;

  logic                           e_valid;
  logic                           e_eval;
  logic [2:0][gn3_pkg::S_W-1:0]   e_weight;
  logic [7:0][2:0][PW-1:0]        e_prod;
  logic                           f_valid;
  logic                           f_eval;
  logic [2:0][gn3_pkg::S_W-1:0]   f_weight;
  logic [7:0][gn3_pkg::DOT_W-1:0] f_dot;

  logic signed [RW-1:0]           offs      [8][3];
  logic signed [PW-1:0]           prod_next [8][3];
  logic signed [SW-1:0]           sum       [8];

  // Corner k is {z, y, x}. The offset to the far corner on an axis is the
  // fraction minus one, which in RW bits is the fraction with a set sign bit.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++) begin
        offs[k][a]      = $signed({1'(k >> a), in_data.frac[a]});
        prod_next[k][a] = offs[k][a] * $signed(in_data.grad[k][a]);
      end
      sum[k] = SW'($signed(e_prod[k][0])) + SW'($signed(e_prod[k][1]))
             + SW'($signed(e_prod[k][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_eval   <= in_data.eval;
      e_weight <= in_data.weight;
      for (int k = 0; k < 8; k++) begin
        for (int a = 0; a < 3; a++) begin
          e_prod[k][a] <= prod_next[k][a];
        end
      end

      f_eval   <= e_eval;
      f_weight <= e_weight;
      for (int k = 0; k < 8; k++) begin
        f_dot[k] <= sum[k][SW-1:CF];
      end
    end
  end

  assign out_valid       = f_valid;
  assign out_data.eval   = f_eval;
  assign out_data.weight = f_weight;
  assign out_data.dot    = f_dot;

endmodule

// ===== design/gn3_lerp.sv =====
// ----------------------------------------------------------------------------
// gn3_lerp: one level of the trilinear blend
// N lanes of lo + floor(t * (hi - lo) / 2^F): the product is registered in
// the first stage, the shift and add in the second.
// ----------------------------------------------------------------------------
module gn3_lerp #(
  parameter int N      = 4,
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [gn3_pkg::S_W-1:0]             t,
  input  logic [N-1:0][gn3_pkg::DOT_W-1:0]    lo,
  input  logic [N-1:0][gn3_pkg::DOT_W-1:0]    hi,
  input  logic [SIDE_W-1:0]                   side,
  output logic                                out_valid,
  output logic [SIDE_W-1:0]                   out_side,
  output logic [N-1:0][gn3_pkg::DOT_W-1:0]    out_val
);

  localparam int DW = gn3_pkg::DOT_W;
  localparam int MW = gn3_pkg::MUL_W;
  localparam int CF = gn3_pkg::COORD_FRAC_BITS;
  localparam int HW = MW - CF;

  logic                   m_valid;
  logic [SIDE_W-1:0]      m_side;
  logic [N-1:0][DW-1:0]   m_lo;
  logic [N-1:0][MW-1:0]   m_prod;
  logic                   o_valid;
  logic [SIDE_W-1:0]      o_side;
  logic [N-1:0][DW-1:0]   o_val;

  logic signed [DW:0]     diff [N];
  logic signed [MW-1:0]   prod [N];
  logic signed [HW-1:0]   sum  [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      diff[i] = (DW+1)'($signed(hi[i])) - (DW+1)'($signed(lo[i]));
      prod[i] = $signed({1'b0, t}) * diff[i];
      sum[i]  = HW'($signed(m_lo[i])) + $signed(m_prod[i][MW-1:CF]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      m_valid <= in_valid;
      o_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side <= side;
      o_side <= m_side;
      for (int i = 0; i < N; i++) begin
        m_lo[i]   <= lo[i];
        m_prod[i] <= prod[i];
        o_val[i]  <= sum[i][DW-1:0];
      end
    end
  end

  assign out_valid = o_valid;
  assign out_side  = o_side;
  assign out_val   = o_val;

endmodule

// ===== design/gradient_noise_3d.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d: pipelined 3D gradient noise
// Load transfers fill the permutation and gradient tables; evaluate
// transfers return one saturated Q2.14 noise sample each.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Carries                                   Transfer yields
//   -------  ---  ----------------------------------------  ----------------
//   req      in   action, coord_x/y/z, entry_index,         one load or one
//                 perm_value, grad_x/y/z                    evaluate
//   rsp      out  noise_value                               one sample
//
// One transfer is taken every cycle while rsp is not stalled. An evaluate's
// sample passes through four lookup stages (the two permutation reads
// and the gradient read are registered RAM reads), two dot-product stages,
// three blend levels of two stages each, and the output register.
// Reset clears only the valid bits; the tables hold nothing defined until
// they are loaded, and an evaluate must only touch loaded entries.
// When rsp is stalled the whole pipeline holds, so req.ready drops; nothing
// is dropped or repeated.
//
module gradient_noise_3d (
  input  logic        clk,
  input  logic        rst,
  gn3_req_if.sink     req,
  gn3_rsp_if.source   rsp
);

  localparam int DW = gn3_pkg::DOT_W;
  localparam int SW = gn3_pkg::S_W;
  localparam int OW = gn3_pkg::OUT_W;

  logic               en;
  gn3_pkg::req_t      req_data;

  logic               lk_valid;
  gn3_pkg::lookup_t   lk_data;
  logic               dt_valid;
  gn3_pkg::corner_t   dt_data;

  // Blend levels: x pairs, then y, then z.
  logic [3:0][DW-1:0] lx_lo, lx_hi, lx_val;
  logic [2*SW:0]      lx_side;
  logic [2*SW:0]      lx_side_q;
  logic               lx_valid;
  logic [1:0][DW-1:0] ly_lo, ly_hi, ly_val;
  logic [SW:0]        ly_side;
  logic [SW:0]        ly_side_q;
  logic               ly_valid;
  logic [0:0][DW-1:0] lz_lo, lz_hi, lz_val;
  logic [0:0]         lz_side;
  logic [0:0]         lz_side_q;
  logic               lz_valid;

  logic               out_valid;
  logic [OW-1:0]      out_noise;
  logic signed [DW+1:0] tripled;
  logic signed [DW+1:0] scaled;
  logic [OW-1:0]      noise_next;

  // The pipeline advances as one unit whenever the output register is free.
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  assign req_data.action      = req.action;
  assign req_data.coord       = {req.coord_z, req.coord_y, req.coord_x};
  assign req_data.entry_index = req.entry_index;
  assign req_data.perm_value  = req.perm_value;
  assign req_data.grad        = {req.grad_z, req.grad_y, req.grad_x};

  gn3_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_req    (req_data),
    .out_valid (lk_valid),
    .out_data  (lk_data)
  );

  gn3_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lk_valid),
    .in_data   (lk_data),
    .out_valid (dt_valid),
    .out_data  (dt_data)
  );

  // Corner k is {z, y, x}; each x level lane blends corners 2j and 2j+1.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lx_lo[j] = dt_data.dot[2*j];
      lx_hi[j] = dt_data.dot[2*j+1];
    end
  end
  assign lx_side = {dt_data.eval, dt_data.weight[1], dt_data.weight[2]};

  gn3_lerp #(.N(4), .SIDE_W(2*SW+1)) u_lerp_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dt_valid),
    .t         (dt_data.weight[0]),
    .lo        (lx_lo),
    .hi        (lx_hi),
    .side      (lx_side),
    .out_valid (lx_valid),
    .out_side  (lx_side_q),
    .out_val   (lx_val)
  );

  assign ly_lo   = {lx_val[2], lx_val[0]};
  assign ly_hi   = {lx_val[3], lx_val[1]};
  assign ly_side = {lx_side_q[2*SW], lx_side_q[SW-1:0]};

  gn3_lerp #(.N(2), .SIDE_W(SW+1)) u_lerp_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lx_valid),
    .t         (lx_side_q[2*SW-1:SW]),
    .lo        (ly_lo),
    .hi        (ly_hi),
    .side      (ly_side),
    .out_valid (ly_valid),
    .out_side  (ly_side_q),
    .out_val   (ly_val)
  );

  assign lz_lo   = ly_val[0];
  assign lz_hi   = ly_val[1];
  assign lz_side = ly_side_q[SW];

  gn3_lerp #(.N(1), .SIDE_W(1)) u_lerp_z (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ly_valid),
    .t         (ly_side_q[SW-1:0]),
    .lo        (lz_lo),
    .hi        (lz_hi),
    .side      (lz_side),
    .out_valid (lz_valid),
    .out_side  (lz_side_q),
    .out_val   (lz_val)
  );

  // Scale by 1.5 with floor, rescale to the output fraction, and saturate.
  always_comb begin
    tripled = (DW+2)'($signed(lz_val[0])) + ((DW+2)'($signed(lz_val[0])) <<< 1);
    scaled  = tripled >>> gn3_pkg::SCALE_SHIFT;
    if (scaled > (DW+2)'(2**(OW-1) - 1)) begin
      noise_next = {1'b0, {(OW-1){1'b1}}};
    end else if (scaled < -(DW+2)'(2**(OW-1))) begin
      noise_next = {1'b1, {(OW-1){1'b0}}};
    end else begin
      noise_next = scaled[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lz_valid && lz_side_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_noise <= noise_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.noise_value = out_noise;

endmodule

// ===== design/gn3_checker.sv =====
// ----------------------------------------------------------------------------
// gn3_checker: port-level checks for the 3D gradient noise block
// Watches the request and response handshakes of the top level.
// ----------------------------------------------------------------------------
module gn3_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] noise_value
);

  // A sample waiting on the output holds until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
    else $error("response changed while stalled");

  // The pipeline moves as one unit: a stalled response blocks new requests.
  a_stall_blocks_req: assert property (@(posedge clk)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while the response is stalled");

  // Nothing is offered on the output right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // With the output empty after reset, requests are taken at once.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> req_ready)
    else $error("request side not ready after reset");

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .noise_value (rsp.noise_value)
);
